// File: rtl/rmsn_pkg.sv
package rmsn_pkg;

  localparam int unsigned SUM_W = 38;
  localparam int unsigned EPS_W = 32;
  localparam logic [EPS_W-1:0] EPS_DEFAULT = 32'd168;

  // Configuration register indexes.
  localparam logic CFG_USE_GAIN = 1'b0;
  localparam logic CFG_EPSILON  = 1'b1;

  typedef struct packed {
    logic load;
    logic clr_sum;
    logic div_init_mean;
    logic div_init_inv;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic rd_en;
    logic rd_last;
  } rmsn_cmd_t;

endpackage

// File: rtl/rmsn_datapath.sv
module rmsn_datapath #(
  parameter int unsigned MAX_LEN     = 64,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned AW          = 6,
  parameter int unsigned CW          = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rmsn_pkg::rmsn_cmd_t cmd_i,
  input  logic [AW-1:0]       addr_i,
  input  logic [CW-1:0]       cnt_i,
  input  logic [15:0]         sample_i,
  input  logic [15:0]         gain_i,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  output logic                emit_done_o,
  output logic [15:0]         normalized_o,
  output logic                last_out_o,
  output logic                out_valid_o
);
  import rmsn_pkg::*;

  localparam int unsigned SW = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
  localparam int unsigned SH = 16 - SW;
  localparam logic [28:0] PMAX = 29'((64'd1 << (SW - 1)) - 64'd1);
  localparam logic [28:0] NMAX = 29'(64'd1 << (SW - 1));

  logic             use_gain_q;
  logic [EPS_W-1:0] eps_q;
  logic [EPS_W-1:0] eps_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_gain_q <= 1'b1;
      eps_q      <= EPS_DEFAULT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_USE_GAIN: use_gain_q <= cfg_wdata_i[0];
        CFG_EPSILON:  eps_q      <= cfg_wdata_i;
        default:      use_gain_q <= use_gain_q;
      endcase
    end
  end

  assign eps_eff = (eps_q == '0) ? EPS_DEFAULT : eps_q;

  // Sample sign extended from the configured sample width.
  logic [15:0]        s_shl;
  logic signed [15:0] s_ext;
  logic signed [31:0] s_sq;
  assign s_shl = sample_i << SH;
  assign s_ext = $signed(s_shl) >>> SH;
  assign s_sq  = s_ext * s_ext;

  logic [SUM_W-1:0] sum_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (cmd_i.clr_sum) begin
      sum_q <= '0;
    end else if (cmd_i.load) begin
      sum_q <= sum_q + SUM_W'(unsigned'(s_sq));
    end
  end

  // Vector store: gain in the upper half, sample in the lower half.
  logic [31:0] mem [MAX_LEN];
  logic [31:0] rd_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem[addr_i] <= {gain_i, s_ext};
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[addr_i];
    end
  end

  // Shared restoring divider, one quotient bit per step.
  logic [63:0] dvd_q;
  logic [38:0] dvs_q;
  logic [38:0] rem_q;
  logic [39:0] rem_sh;
  logic        q_bit;
  assign rem_sh = {rem_q, dvd_q[63]};
  assign q_bit  = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init_mean) begin
      dvd_q <= {26'd0, sum_q};
      dvs_q <= 39'(cnt_i);
      rem_q <= '0;
    end else if (cmd_i.div_init_inv) begin
      dvd_q <= '1;
      dvs_q <= dvd_q[38:0] + {7'd0, eps_eff};
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[62:0], q_bit};
      rem_q <= q_bit ? 39'(rem_sh - {1'b0, dvs_q}) : rem_sh[38:0];
    end
  end

  // Digit-by-digit square root, one root bit per step.
  logic [63:0] sa_q;
  logic [32:0] srem_q;
  logic [31:0] root_q;
  logic [34:0] srs;
  logic [34:0] trial;
  logic        r_bit;
  assign srs   = {srem_q, sa_q[63:62]};
  assign trial = {1'b0, root_q, 2'b01};
  assign r_bit = srs >= trial;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      sa_q   <= dvd_q;
      srem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      sa_q   <= {sa_q[61:0], 2'b00};
      srem_q <= r_bit ? 33'(srs - trial) : srs[32:0];
      root_q <= {root_q[30:0], r_bit};
    end
  end

  // Emit pipeline: read, magnitude product, scale by the inverse root, round.
  logic        v0_q, v1_q, v2_q;
  logic        l0_q, l1_q, l2_q;
  logic        n1_q, n2_q;
  logic [30:0] a_q;
  logic [62:0] p_q;
  logic [15:0] rs_ext;
  logic [15:0] rg;
  logic [15:0] s_mag;
  logic [15:0] g_mag;
  logic [31:0] sg;

  assign rs_ext = rd_q[15:0];
  assign rg     = rd_q[31:16];
  assign s_mag  = rs_ext[15] ? 16'(16'd0 - rs_ext) : rs_ext;
  assign g_mag  = rg[15] ? 16'(16'd0 - rg) : rg;
  assign sg     = s_mag * g_mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= cmd_i.rd_en;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    l0_q <= cmd_i.rd_last;
    l1_q <= l0_q;
    l2_q <= l1_q;
    // Without gain, a shift by 14 puts both cases on the same final shift.
    if (use_gain_q) begin
      a_q  <= sg[30:0];
      n1_q <= rs_ext[15] ^ rg[15];
    end else begin
      a_q  <= {1'b0, s_mag, 14'd0};
      n1_q <= rs_ext[15];
    end
    p_q  <= 63'(a_q * root_q);
    n2_q <= n1_q;
  end

  logic [63:0] p_rnd;
  logic [28:0] mag;
  logic [28:0] mag_sat;
  assign p_rnd = {1'b0, p_q} + (64'd1 << 33);
  assign mag   = p_rnd[62:34];

  always_comb begin
    if (n2_q) begin
      mag_sat = (mag > NMAX) ? NMAX : mag;
    end else begin
      mag_sat = (mag > PMAX) ? PMAX : mag;
    end
  end

  logic        ov_q;
  logic        ol_q;
  logic [15:0] od_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ol_q <= l2_q;
    od_q <= n2_q ? 16'(29'd0 - mag_sat) : mag_sat[15:0];
  end

  assign out_valid_o  = ov_q;
  assign last_out_o   = ol_q;
  assign normalized_o = od_q;
  assign emit_done_o  = ov_q & ol_q;

endmodule

// File: rtl/rmsn_ctrl.sv
module rmsn_ctrl #(
  parameter int unsigned MAX_LEN = 64,
  parameter int unsigned AW      = 6,
  parameter int unsigned CW      = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                last_in_i,
  input  logic                emit_done_i,
  output logic                busy,
  output rmsn_pkg::rmsn_cmd_t cmd_o,
  output logic [AW-1:0]       addr_o,
  output logic [CW-1:0]       cnt_o
);
  import rmsn_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MINIT = 3'd1;
  localparam logic [2:0] ST_DIVM  = 3'd2;
  localparam logic [2:0] ST_DIVI  = 3'd3;
  localparam logic [2:0] ST_SQRT  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;
  localparam logic [2:0] ST_DRAIN = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [5:0]    step_q, step_d;
  logic          room;

  assign room = cnt_q < CW'(MAX_LEN);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    step_d  = step_q;
    cmd_o   = '0;
    addr_o  = cnt_q[AW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          // Elements beyond the store depth are dropped but still may close the vector.
          if (room) begin
            cmd_o.load = 1'b1;
            cnt_d      = cnt_q + 1'b1;
          end
          if (last_in_i) begin
            if (cnt_d == '0) begin
              cmd_o.clr_sum = 1'b1;
            end else begin
              state_d = ST_MINIT;
            end
          end
        end
      end
      ST_MINIT: begin
        cmd_o.div_init_mean = 1'b1;
        step_d  = '0;
        state_d = ST_DIVM;
      end
      ST_DIVM: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == '1) begin
          state_d = ST_DIVI;
        end
      end
      ST_DIVI: begin
        // The first cycle seeds the inverse division from the mean.
        if (step_q == '0 && idx_q == '0) begin
          cmd_o.div_init_inv = 1'b1;
          idx_d = CW'(1);
        end else begin
          cmd_o.div_step = 1'b1;
          step_d = step_q + 1'b1;
          if (step_q == '1) begin
            cmd_o.div_step = 1'b1;
            state_d = ST_SQRT;
            idx_d   = '0;
          end
        end
      end
      ST_SQRT: begin
        if (idx_q == '0) begin
          cmd_o.sqrt_init = 1'b1;
          idx_d  = CW'(1);
          step_d = '0;
        end else begin
          cmd_o.sqrt_step = 1'b1;
          step_d = step_q + 1'b1;
          if (step_q == 6'd31) begin
            state_d = ST_EMIT;
            idx_d   = '0;
          end
        end
      end
      ST_EMIT: begin
        cmd_o.rd_en   = 1'b1;
        addr_o        = idx_q[AW-1:0];
        idx_d         = idx_q + 1'b1;
        if (idx_d == cnt_q) begin
          cmd_o.rd_last = 1'b1;
          state_d       = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (emit_done_i) begin
          cmd_o.clr_sum = 1'b1;
          cnt_d   = '0;
          idx_d   = '0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
    end
  end

  assign busy  = state_q != ST_IDLE;
  assign cnt_o = cnt_q;

endmodule

// File: rtl/rms_normalizer.sv
// Channel   | Ports                                         | Handshake
// ----------+-----------------------------------------------+--------------------------
// input     | sample_i, gain_i, last_in_i                   | start high, busy low
// config    | cfg_we_i, cfg_idx_i, cfg_wdata_i              | cfg_we_i high, no wait
// result    | normalized_o, last_out_o                      | out_valid_o, one cycle
//
// Elements load one per cycle while busy is low. The last item of a vector starts
// the shared restoring divider, first for the mean and then for the inverse, and then
// the digit-by-digit square root. The emit pass then gives one result per cycle from
// the store through the read, product, scale and output registers. Reset clears the
// control state and the sum; the receiver cannot stall.
module rms_normalizer #(
  parameter int unsigned MAX_LEN     = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] sample_i,
  input  logic [15:0] gain_i,
  input  logic        last_in_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output logic [15:0] normalized_o,
  output logic        last_out_o,
  output logic        out_valid_o
);
  import rmsn_pkg::*;

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  rmsn_cmd_t     cmd;
  logic [AW-1:0] addr;
  logic [CW-1:0] cnt;
  logic          emit_done;

  rmsn_ctrl #(
    .MAX_LEN(MAX_LEN),
    .AW     (AW),
    .CW     (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .last_in_i  (last_in_i),
    .emit_done_i(emit_done),
    .busy       (busy),
    .cmd_o      (cmd),
    .addr_o     (addr),
    .cnt_o      (cnt)
  );

  rmsn_datapath #(
    .MAX_LEN    (MAX_LEN),
    .SAMPLE_BITS(SAMPLE_BITS),
    .AW         (AW),
    .CW         (CW)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .addr_i      (addr),
    .cnt_i       (cnt),
    .sample_i    (sample_i),
    .gain_i      (gain_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .emit_done_o (emit_done),
    .normalized_o(normalized_o),
    .last_out_o  (last_out_o),
    .out_valid_o (out_valid_o)
  );

endmodule
